>>> hw/rtl/drb_pkg.sv
// ----------------------------------------------------------------------------
// drb_pkg: shared constants and types for the decile rank binning block
// Holds the column capacity, derived widths and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package drb_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int SAMPLE_W    = 32;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int DECILE_W    = 4;
   localparam int NUM_BINS    = 10;
   localparam int NUM_W       = CNT_W + 4;

   typedef struct packed {
      logic accept;
      logic read_pivot;
      logic load_pivot;
      logic sweep;
      logic emit;
   } drb_cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic item_last;
      logic out_free;
   } drb_status_type;

endpackage

>>> hw/rtl/drb_ctrl.sv
// ----------------------------------------------------------------------------
// drb_ctrl: sequencing state machine
// Collects samples until the closing transfer, then walks each stored sample
// through a pivot read, a compare sweep and a result transfer.
// ----------------------------------------------------------------------------
module drb_ctrl
   import drb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last_sample,
   input  drb_status_type status,
   output drb_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RD_PIV = 3'd1;
   localparam logic [2:0] ST_LD_PIV = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = 1'b1;
            if (req_valid && req_last_sample) begin
               state_in = ST_RD_PIV;
            end
         end
         ST_RD_PIV: begin
            cmd.read_pivot = 1'b1;
            state_in       = ST_LD_PIV;
         end
         ST_LD_PIV: begin
            cmd.load_pivot = 1'b1;
            state_in       = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.item_last ? ST_IDLE : ST_RD_PIV;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/drb_datapath.sv
// ----------------------------------------------------------------------------
// drb_datapath: sample store, rank counter and result register
// Stores the column, counts smaller samples one compare per cycle and turns
// each rank into a decile with a bank of threshold compares.
// ----------------------------------------------------------------------------
module drb_datapath
   import drb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  drb_cmd_type                cmd,
   output drb_status_type             status,
   input  logic                       req_valid,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DECILE_W-1:0]        rsp_decile,
   output logic                       rsp_last_result,
   output logic                       rsp_overflow
);

   logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SAMPLE_W-1:0] pivot_ff;
   logic [ADDR_W-1:0]          rd_addr;
   logic [CNT_W-1:0]           count_ff;
   logic                       dropped_ff;
   logic [ADDR_W-1:0]          item_ff;
   logic [ADDR_W-1:0]          scan_ff;
   logic [CNT_W-1:0]           rank_ff;
   logic                       take;
   logic                       full;
   logic [CNT_W-1:0]           count_m1;
   logic [NUM_W-1:0]           num;
   logic [DECILE_W-1:0]        decile;
   logic                       rsp_valid_ff;
   logic [DECILE_W-1:0]        decile_ff;
   logic                       last_ff;
   logic                       ovf_ff;

   assign take     = cmd.accept && req_valid;
   assign full     = (count_ff == CNT_W'(MAX_SAMPLES));
   assign count_m1 = count_ff - CNT_W'(1);

   assign status.sweep_done = ({1'b0, scan_ff} == count_m1);
   assign status.item_last  = ({1'b0, item_ff} == count_m1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (cmd.read_pivot) begin
         rd_addr = item_ff;
      end else if (cmd.load_pivot) begin
         rd_addr = '0;
      end else begin
         rd_addr = scan_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (take && !full) begin
         mem[count_ff[ADDR_W-1:0]] <= req_sample_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      logic [NUM_W-1:0] thr;
      num    = NUM_W'(rank_ff) * NUM_W'(NUM_BINS) + NUM_W'(5);
      decile = '0;
      for (int k = 1; k < NUM_BINS; k++) begin
         thr = NUM_W'(k) * NUM_W'(count_ff);
         if (num >= thr) begin
            decile = decile + DECILE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '0;
      end else if (cmd.emit) begin
         item_ff <= item_ff + ADDR_W'(1);
      end
      if (cmd.load_pivot) begin
         pivot_ff <= rd_data_ff;
         scan_ff  <= '0;
         rank_ff  <= '0;
      end else if (cmd.sweep) begin
         scan_ff <= scan_ff + ADDR_W'(1);
         if (rd_data_ff < pivot_ff) begin
            rank_ff <= rank_ff + CNT_W'(1);
         end
      end
      if (cmd.emit) begin
         decile_ff <= decile;
         last_ff   <= status.item_last;
         ovf_ff    <= dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            if (full) begin
               dropped_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end else if (cmd.emit && status.item_last) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_decile      = decile_ff;
   assign rsp_last_result = last_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

>>> hw/rtl/decile_rank_binning.sv
// ----------------------------------------------------------------------------
// decile_rank_binning: ranks a column of Q16.16 samples into deciles
// Samples are taken while idle; after the closing transfer each stored
// sample passes through a pivot read, a pivot load, a compare sweep over the
// single store read port and a result load, which waits for a free output.
// No new sample is taken until the last result of the column is loaded.
// Reset (synchronous, active high) empties the column and the result register.
// ----------------------------------------------------------------------------
module decile_rank_binning
   import drb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DECILE_W-1:0]        rsp_decile,
   output logic                       rsp_last_result,
   output logic                       rsp_overflow
);

   drb_cmd_type    cmd;
   drb_status_type status;

   drb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .status          (status),
      .cmd             (cmd)
   );

   drb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_valid),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_decile       (rsp_decile),
      .rsp_last_result  (rsp_last_result),
      .rsp_overflow     (rsp_overflow)
   );

   assign req_ready = cmd.accept;

   a_decile_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decile < DECILE_W'(NUM_BINS)))
      else $error("decile out of range");

   a_close_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_sample) |=> !req_ready)
      else $error("input taken after closing transfer");

   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.read_pivot, cmd.load_pivot, cmd.sweep, cmd.emit}))
      else $error("conflicting datapath commands");

   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result load lost");

endmodule
